### hdl/ccmh_pkg.sv
package ccmh_pkg;

    // Histogram geometry
    localparam int DCA_ROWS    = 14;
    localparam int MASS_BINS   = 60;
    localparam int COUNT_WIDTH = 32;

    localparam int TABLE_BINS = 14;
    localparam int HIST_ROW   = MASS_BINS + 2;
    localparam int HIST_DEPTH = DCA_ROWS * HIST_ROW;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    localparam int DCA_SCAN = (DCA_ROWS < TABLE_BINS) ? DCA_ROWS : TABLE_BINS;
    localparam int DCA_W    = (DCA_ROWS > 1) ? $clog2(DCA_ROWS) : 1;
    localparam int MBIN_W   = $clog2(HIST_ROW);

    // Output field widths
    localparam int OUT_DCA_W   = 4;
    localparam int OUT_MBIN_W  = 6;
    localparam int OUT_COUNT_W = 32;

    // Mass binning, 0.1 MeV units
    localparam logic [15:0] MASS_LO   = 16'd17000;
    localparam int          MASS_SPAN = 3000;
    localparam logic [15:0] MASS_HI   = 16'(17000 + MASS_SPAN);
    localparam int          MASS_DW   = $clog2(MASS_SPAN);

    // floor(d * MASS_BINS / MASS_SPAN) as a multiply by a rounded-up reciprocal
    localparam int MASS_SHIFT = $clog2(MASS_SPAN * MASS_SPAN);
    localparam longint unsigned MASS_MULT =
        ((longint'(MASS_BINS) << MASS_SHIFT) + longint'(MASS_SPAN) - 1) / MASS_SPAN;
    localparam int MASS_MULT_W = $clog2(MASS_MULT + 1);

    // Candidate pT window, 0.01 GeV, strict
    localparam logic [15:0] PT_WIN_LO = 16'd300;
    localparam logic [15:0] PT_WIN_HI = 16'd3000;

    // DCA bin edges, 0.00001 cm
    localparam logic [15:0] DCA_EDGES [TABLE_BINS + 1] = '{
        16'd0,    16'd100,  16'd230,  16'd390,  16'd590,
        16'd800,  16'd1180, 16'd1600, 16'd2140, 16'd2810,
        16'd3670, 16'd4760, 16'd7000, 16'd7580, 16'd8170
    };

    // Queue depths
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PW    = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH = 4;
    localparam int RES_PW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = RES_PW + 1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MIN_CAND_PT     = 3'd0,
        REG_MIN_DAUGHTER_PT = 3'd1,
        REG_MAX_DAU_ABS_ETA = 3'd2,
        REG_MIN_ABS_RAP     = 3'd3,
        REG_MAX_ABS_RAP     = 3'd4,
        REG_MAX_POINT_ANGLE = 3'd5,
        REG_MIN_VERTEX_PROB = 3'd6,
        REG_MIN_DECAY_SIG   = 3'd7
    } reg_idx_t;

    // Classified item from front to back
    typedef struct packed {
        logic              filled;
        logic [DCA_W-1:0]  dbin;
        logic [MBIN_W-1:0] mbin;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic                   filled;
        logic [OUT_DCA_W-1:0]   dbin;
        logic [OUT_MBIN_W-1:0]  mbin;
        logic [OUT_COUNT_W-1:0] count;
    } res_t;

endpackage

### hdl/ccmh_front.sv
module ccmh_front
    import ccmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_take,
    input  logic [15:0] cand_mass,
    input  logic [15:0] cand_pt,
    input  logic [15:0] cand_rapidity,
    input  logic [15:0] first_eta,
    input  logic [15:0] second_eta,
    input  logic [15:0] first_pt,
    input  logic [15:0] second_pt,
    input  logic [15:0] vertex_prob,
    input  logic [14:0] pointing_angle,
    input  logic [15:0] decay_signif,
    input  logic [15:0] impact_dca,
    input  logic        cmd_full,
    output logic        cmd_push,
    output cmd_t        cmd_item,
    output logic        busy
);

    logic [15:0] min_cand_pt_reg;
    logic [15:0] min_daughter_pt_reg;
    logic [14:0] max_dau_abs_eta_reg;
    logic [14:0] min_abs_rap_reg;
    logic [14:0] max_abs_rap_reg;
    logic [14:0] max_point_angle_reg;
    logic [15:0] min_vertex_prob_reg;
    logic [15:0] min_decay_sig_reg;

    logic f_vld_reg;
    cmd_t f_cmd_reg;

    logic [16:0] arap;
    logic [16:0] aeta1;
    logic [16:0] aeta2;
    logic        pass;
    logic        found;
    logic [DCA_W-1:0]  dbin;
    logic [MBIN_W-1:0] mbin;
    logic [MASS_DW-1:0] mass_off;
    logic [MASS_DW+MASS_MULT_W-1:0] mass_prod;
    cmd_t cls;

    // Two's complement magnitude; the most negative code maps to 32768
    function automatic logic [16:0] mag16(input logic [15:0] v);
        return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cand_pt_reg     <= 16'd200;
            min_daughter_pt_reg <= 16'd150;
            max_dau_abs_eta_reg <= 15'd2200;
            min_abs_rap_reg     <= 15'd1200;
            max_abs_rap_reg     <= 15'd2000;
            max_point_angle_reg <= 15'd1200;
            min_vertex_prob_reg <= 16'd5243;
            min_decay_sig_reg   <= 16'd500;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MIN_CAND_PT:     min_cand_pt_reg     <= cfg_data;
                REG_MIN_DAUGHTER_PT: min_daughter_pt_reg <= cfg_data;
                REG_MAX_DAU_ABS_ETA: max_dau_abs_eta_reg <= cfg_data[14:0];
                REG_MIN_ABS_RAP:     min_abs_rap_reg     <= cfg_data[14:0];
                REG_MAX_ABS_RAP:     max_abs_rap_reg     <= cfg_data[14:0];
                REG_MAX_POINT_ANGLE: max_point_angle_reg <= cfg_data[14:0];
                REG_MIN_VERTEX_PROB: min_vertex_prob_reg <= cfg_data;
                REG_MIN_DECAY_SIG:   min_decay_sig_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Selection cuts
    always_comb
    begin
        arap  = mag16(cand_rapidity);
        aeta1 = mag16(first_eta);
        aeta2 = mag16(second_eta);
        pass  = (cand_pt >= min_cand_pt_reg)
             && (first_pt >= min_daughter_pt_reg)
             && (second_pt >= min_daughter_pt_reg)
             && (aeta1 <= {2'b00, max_dau_abs_eta_reg})
             && (aeta2 <= {2'b00, max_dau_abs_eta_reg})
             && (arap >= {2'b00, min_abs_rap_reg})
             && (arap <= {2'b00, max_abs_rap_reg})
             && (cand_pt > PT_WIN_LO) && (cand_pt < PT_WIN_HI)
             && (pointing_angle <= max_point_angle_reg)
             && (vertex_prob >= min_vertex_prob_reg)
             && (decay_signif >= min_decay_sig_reg);
    end

    // DCA bin: strict edges, first interval that holds the value
    always_comb
    begin
        found = 1'b0;
        dbin  = '0;
        for (int i = 0; i < DCA_SCAN; i++)
        begin
            if (!found && impact_dca > DCA_EDGES[i] && impact_dca < DCA_EDGES[i + 1])
            begin
                found = 1'b1;
                dbin  = DCA_W'(i);
            end
        end
    end

    // Mass bin
    always_comb
    begin
        mass_off  = MASS_DW'(cand_mass - MASS_LO);
        mass_prod = (MASS_DW + MASS_MULT_W)'(mass_off)
                  * (MASS_DW + MASS_MULT_W)'(MASS_MULT);
        if (cand_mass < MASS_LO)
            mbin = '0;
        else if (cand_mass >= MASS_HI)
            mbin = MBIN_W'(MASS_BINS + 1);
        else
            mbin = MBIN_W'(mass_prod >> MASS_SHIFT) + MBIN_W'(1);
    end

    // Classified item; rejected items carry all-zero fields
    always_comb
    begin
        if (pass && found)
        begin
            cls.filled = 1'b1;
            cls.dbin   = dbin;
            cls.mbin   = mbin;
            cls.addr   = ADDR_W'(dbin * HIST_ROW) + ADDR_W'(mbin);
        end
        else
        begin
            cls = '0;
        end
    end

    // Output stage into the command queue
    assign cmd_push = f_vld_reg && !cmd_full;
    assign cmd_item = f_cmd_reg;
    assign busy     = f_vld_reg && cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (in_take)
            f_vld_reg <= 1'b1;
        else if (cmd_push)
            f_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            f_cmd_reg <= cls;
    end

endmodule

### hdl/ccmh_cmd_fifo.sv
module ccmh_cmd_fifo
    import ccmh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_item,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_item,
    output logic empty
);

    cmd_t              slots [CMD_DEPTH];
    logic [CMD_PW-1:0] wr_ptr_reg;
    logic [CMD_PW-1:0] rd_ptr_reg;
    logic [CMD_PW:0]   cnt_reg;

    assign full    = (cnt_reg == (CMD_PW + 1)'(CMD_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_item = slots[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == CMD_PW'(CMD_DEPTH - 1)) ? '0
                            : wr_ptr_reg + CMD_PW'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == CMD_PW'(CMD_DEPTH - 1)) ? '0
                            : rd_ptr_reg + CMD_PW'(1);
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + (CMD_PW + 1)'(1);
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - (CMD_PW + 1)'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots[wr_ptr_reg] <= wr_item;
    end

endmodule

### hdl/ccmh_res_fifo.sv
module ccmh_res_fifo
    import ccmh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  res_t              wr_item,
    input  logic              rd_en,
    output res_t              rd_item,
    output logic              empty,
    output logic [RES_CW-1:0] count
);

    res_t              slots [RES_DEPTH];
    logic [RES_PW-1:0] wr_ptr_reg;
    logic [RES_PW-1:0] rd_ptr_reg;
    logic [RES_CW-1:0] cnt_reg;

    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign rd_item = slots[rd_ptr_reg];

    // Pointers and fill level; the writer never pushes into a full queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == RES_PW'(RES_DEPTH - 1)) ? '0
                            : wr_ptr_reg + RES_PW'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == RES_PW'(RES_DEPTH - 1)) ? '0
                            : rd_ptr_reg + RES_PW'(1);
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + RES_CW'(1);
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - RES_CW'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots[wr_ptr_reg] <= wr_item;
    end

endmodule

### hdl/ccmh_hist.sv
module ccmh_hist
    import ccmh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  cmd_t              cmd_item,
    output logic              cmd_pop,
    input  logic [RES_CW-1:0] res_count,
    output logic              res_push,
    output res_t              res_item,
    output logic              clearing
);

    logic [COUNT_WIDTH-1:0] hist_mem [HIST_DEPTH];

    logic                   clr_reg;
    logic [ADDR_W-1:0]      clr_idx_reg;
    logic                   a_vld_reg;
    cmd_t                   a_cmd_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   lw_vld_reg;
    logic [ADDR_W-1:0]      lw_addr_reg;
    logic [COUNT_WIDTH-1:0] lw_data_reg;

    logic                   credit_ok;
    logic [COUNT_WIDTH-1:0] old_cnt;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    assign clearing = clr_reg;

    // Issue: room in the result queue for this item and the one in flight
    assign credit_ok = ({1'b0, res_count} + (RES_CW + 1)'(a_vld_reg))
                     < (RES_CW + 1)'(RES_DEPTH);
    assign cmd_pop   = !clr_reg && !cmd_empty && credit_ok;

    // Read-modify-write; forward the write made on the same edge as our read
    always_comb
    begin
        old_cnt = (lw_vld_reg && lw_addr_reg == a_cmd_reg.addr) ? lw_data_reg
                                                                : rd_data_reg;
        new_cnt = (&old_cnt) ? old_cnt : old_cnt + COUNT_WIDTH'(1);
        wr_en   = clr_reg || (a_vld_reg && a_cmd_reg.filled);
        wr_addr = clr_reg ? clr_idx_reg : a_cmd_reg.addr;
        wr_data = clr_reg ? '0 : new_cnt;
    end

    // Result
    always_comb
    begin
        res_push       = a_vld_reg;
        res_item.filled = a_cmd_reg.filled;
        res_item.dbin  = OUT_DCA_W'(a_cmd_reg.dbin);
        res_item.mbin  = OUT_MBIN_W'(a_cmd_reg.mbin);
        res_item.count = a_cmd_reg.filled ? OUT_COUNT_W'(new_cnt) : '0;
    end

    // Histogram store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wr_addr] <= wr_data;
        if (cmd_pop)
            rd_data_reg <= hist_mem[cmd_item.addr];
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clr_reg)
        begin
            if (clr_idx_reg == ADDR_W'(HIST_DEPTH - 1))
                clr_reg <= 1'b0;
            clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
        end
    end

    // Pipeline stage and last-write bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            lw_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= cmd_pop;
            if (a_vld_reg && a_cmd_reg.filled)
                lw_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            a_cmd_reg <= cmd_item;
        if (a_vld_reg && a_cmd_reg.filled)
        begin
            lw_addr_reg <= a_cmd_reg.addr;
            lw_data_reg <= new_cnt;
        end
    end

endmodule

### hdl/candidate_cut_and_mass_histogram_unit.sv
// Decay-candidate selection and mass histogram.
// Input channel: present a candidate on the field ports with push high; it is
// taken at a rising edge where push is high and full is low.
// Result channel: while empty is low the oldest result is on was_filled,
// dca_bin, mass_bin and bin_count; pop high at an edge takes it. Every
// candidate gives exactly one result, in order.
// Configuration: cfg_index selects one of the eight cut registers, written
// with cfg_data when cfg_valid is high (cfg_ready is always high). Write only
// while no candidate is in flight.
// Throughput is one candidate per cycle while full is low; the histogram
// read-modify-write is pipelined with a bypass of the previous write.
// A candidate passes the front register, command queue, histogram stage A
// and result queue. After reset the histogram is cleared one entry a cycle,
// all 868 entries, with full held high; configuration writes are taken then.
// When the receiver stops popping, the result queue fills, the back end
// stops issuing, the command queue fills and full rises; nothing is lost.
module candidate_cut_and_mass_histogram_unit
    import ccmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] cand_mass,
    input  logic [15:0] cand_pt,
    input  logic [15:0] cand_rapidity,
    input  logic [15:0] first_eta,
    input  logic [15:0] second_eta,
    input  logic [15:0] first_pt,
    input  logic [15:0] second_pt,
    input  logic [15:0] vertex_prob,
    input  logic [14:0] pointing_angle,
    input  logic [15:0] decay_signif,
    input  logic [15:0] impact_dca,
    output logic        empty,
    input  logic        pop,
    output logic        was_filled,
    output logic [3:0]  dca_bin,
    output logic [5:0]  mass_bin,
    output logic [31:0] bin_count
);

    logic              in_take;
    logic              front_busy;
    logic              clearing;
    logic              cmd_push;
    cmd_t              cmd_wr_item;
    logic              cmd_full;
    logic              cmd_pop;
    cmd_t              cmd_rd_item;
    logic              cmd_empty;
    logic              res_push;
    res_t              res_wr_item;
    res_t              res_rd_item;
    logic [RES_CW-1:0] res_count;

    assign cfg_ready = 1'b1;
    assign full      = clearing || front_busy;
    assign in_take   = push && !full;

    ccmh_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_take        (in_take),
        .cand_mass      (cand_mass),
        .cand_pt        (cand_pt),
        .cand_rapidity  (cand_rapidity),
        .first_eta      (first_eta),
        .second_eta     (second_eta),
        .first_pt       (first_pt),
        .second_pt      (second_pt),
        .vertex_prob    (vertex_prob),
        .pointing_angle (pointing_angle),
        .decay_signif   (decay_signif),
        .impact_dca     (impact_dca),
        .cmd_full       (cmd_full),
        .cmd_push       (cmd_push),
        .cmd_item       (cmd_wr_item),
        .busy           (front_busy)
    );

    ccmh_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_item (cmd_wr_item),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_item (cmd_rd_item),
        .empty   (cmd_empty)
    );

    ccmh_hist u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_item  (cmd_rd_item),
        .cmd_pop   (cmd_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_item  (res_wr_item),
        .clearing  (clearing)
    );

    ccmh_res_fifo u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_item (res_wr_item),
        .rd_en   (pop && !empty),
        .rd_item (res_rd_item),
        .empty   (empty),
        .count   (res_count)
    );

    assign was_filled = res_rd_item.filled;
    assign dca_bin    = res_rd_item.dbin;
    assign mass_bin   = res_rd_item.mbin;
    assign bin_count  = res_rd_item.count;

endmodule
